[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define RFDD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rfdd assertion failed");

// Checked at every edge, reset cycles included.
`define RFDD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rfdd assertion failed");

`endif

[design/rfdd_pkg.sv]
package rfdd_pkg;

  localparam int NUM_REGS  = 14;
  localparam int ENV_INDEX = 13;

  localparam int REG_W   = 8;
  localparam int MASK_W  = NUM_REGS;
  localparam int TIME_W  = 63;
  localparam int STAMP_W = TIME_W + 1;
  localparam int DUR_W   = 32;
  localparam int SKIP_W  = 32;
  localparam int LOW_W   = 64;
  localparam int HIGH_W  = 48;
  localparam int REGS_W  = LOW_W + HIGH_W;

  localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(20000000);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [REG_W-1:0] reg_byte_t;

  // One classified chunk on its way from the front end to the back end.
  typedef struct packed {
    logic                close;
    logic [MASK_W-1:0]   wmask;
    logic [REGS_W-1:0]   regs;
    logic [TIME_W-1:0]   stamp;
  } rfdd_entry_t;

endpackage

[design/rfdd_in_if.sv]
interface rfdd_in_if;
  import rfdd_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   chunk_time;
  logic [MASK_W-1:0]   write_mask;
  logic [LOW_W-1:0]    regs_low;
  logic [HIGH_W-1:0]   regs_high;

  modport source (output valid, chunk_time, write_mask, regs_low, regs_high, input ready);
  modport sink (input valid, chunk_time, write_mask, regs_low, regs_high, output ready);
  modport monitor (input valid, ready, chunk_time, write_mask, regs_low, regs_high);

endinterface

[design/rfdd_out_if.sv]
interface rfdd_out_if;
  import rfdd_pkg::*;

  logic                valid;
  logic                ready;
  logic [SKIP_W-1:0]   frames_skipped;
  logic [MASK_W-1:0]   delta_mask;
  logic [LOW_W-1:0]    delta_low;
  logic [HIGH_W-1:0]   delta_high;
  logic [LOW_W-1:0]    base_low;
  logic [HIGH_W-1:0]   base_high;
  logic [TIME_W-1:0]   base_time;

  modport source (
    output valid, frames_skipped, delta_mask, delta_low, delta_high,
           base_low, base_high, base_time,
    input  ready
  );
  modport sink (
    input  valid, frames_skipped, delta_mask, delta_low, delta_high,
           base_low, base_high, base_time,
    output ready
  );
  modport monitor (
    input valid, ready, frames_skipped, delta_mask, delta_low, delta_high,
          base_low, base_high, base_time
  );

endinterface

[design/rfdd_front.sv]
module rfdd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rfdd_pkg::DUR_W-1:0]  cfg_wr_data,
  rfdd_in_if.sink                     in_chan,
  output logic                        push,
  output rfdd_pkg::rfdd_entry_t       push_entry,
  input  logic                        q_full
);
  import rfdd_pkg::*;

  logic [DUR_W-1:0]   frame_dur_r;
  logic [TIME_W-1:0]  base_stamp_r;
  logic [TIME_W-1:0]  base_stamp_nxt;
  logic [STAMP_W-1:0] boundary;
  logic               is_close;

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

  // The boundary is formed one bit wider than a timestamp so that it cannot wrap.
  assign boundary = {1'b0, base_stamp_r} + {{(STAMP_W - DUR_W){1'b0}}, frame_dur_r};
  assign is_close = {1'b0, in_chan.chunk_time} >= boundary;

  always_comb begin
    push_entry.close = is_close;
    push_entry.wmask = in_chan.write_mask;
    push_entry.regs  = {in_chan.regs_high, in_chan.regs_low};
    push_entry.stamp = base_stamp_r;
    // A closing chunk proves the boundary is inside the timestamp range.
    base_stamp_nxt   = (push && is_close) ? boundary[TIME_W-1:0] : base_stamp_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_dur_r  <= DUR_RESET;
      base_stamp_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_dur_r <= cfg_wr_data;
      end
      base_stamp_r <= base_stamp_nxt;
    end
  end

endmodule

[design/rfdd_queue.sv]
module rfdd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  rfdd_pkg::rfdd_entry_t  push_entry,
  output logic                   full,
  input  logic                   pop,
  output rfdd_pkg::rfdd_entry_t  pop_entry,
  output logic                   pop_valid
);
  import rfdd_pkg::*;

  rfdd_entry_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full      = count_r == QCNT_W'(QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

[design/rfdd_back.sv]
module rfdd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  input  rfdd_pkg::rfdd_entry_t  pop_entry,
  output logic                   pop,
  rfdd_out_if.source             out_chan
);
  import rfdd_pkg::*;

  reg_byte_t          actual_r [NUM_REGS];
  reg_byte_t          base_r   [NUM_REGS];
  logic [MASK_W-1:0]  changed_r;
  logic [SKIP_W-1:0]  skip_r;

  reg_byte_t          merge_actual [NUM_REGS];
  logic [MASK_W-1:0]  merge_changed;
  logic [MASK_W-1:0]  dmask;
  logic [REGS_W-1:0]  dregs;
  logic [REGS_W-1:0]  bregs;
  logic [SKIP_W-1:0]  skip_inc;
  logic               emit;
  logic               out_free;
  logic               do_merge;
  logic               do_close;
  logic               load;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [SKIP_W-1:0]  frames_skipped_r;
  logic [MASK_W-1:0]  delta_mask_r;
  logic [REGS_W-1:0]  delta_r;
  logic [REGS_W-1:0]  base_regs_r;
  logic [TIME_W-1:0]  base_time_r;

  always_comb begin
    merge_changed = changed_r;
    dmask         = '0;
    dregs         = '0;
    bregs         = '0;
    for (int i = 0; i < NUM_REGS; i++) begin
      merge_actual[i] = actual_r[i];
      if (pop_entry.wmask[i]) begin
        merge_actual[i] = pop_entry.regs[i*REG_W +: REG_W];
        if (i == ENV_INDEX || actual_r[i] != pop_entry.regs[i*REG_W +: REG_W]) begin
          merge_changed[i] = 1'b1;
        end
      end
      dmask[i] = changed_r[i] && (i == ENV_INDEX || base_r[i] != actual_r[i]);
      if (dmask[i]) begin
        dregs[i*REG_W +: REG_W] = actual_r[i];
      end
      bregs[i*REG_W +: REG_W] = base_r[i];
    end
  end

  assign skip_inc = (skip_r == '1) ? skip_r : skip_r + 1'b1;
  assign emit     = dmask != '0;
  assign out_free = !out_valid_r || out_chan.ready;
  // A merge never touches the output register, so it proceeds under a stall.
  assign pop      = pop_valid && (!pop_entry.close || out_free);
  assign do_merge = pop && !pop_entry.close;
  assign do_close = pop && pop_entry.close;
  assign load     = do_close && emit;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        actual_r[i] <= '0;
        base_r[i]   <= '0;
      end
      changed_r   <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_merge) begin
        actual_r  <= merge_actual;
        changed_r <= merge_changed;
      end
      if (do_close) begin
        base_r    <= actual_r;
        changed_r <= '0;
        skip_r    <= emit ? '0 : skip_inc;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frames_skipped_r <= skip_inc;
      delta_mask_r     <= dmask;
      delta_r          <= dregs;
      base_regs_r      <= bregs;
      base_time_r      <= pop_entry.stamp;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.frames_skipped = frames_skipped_r;
  assign out_chan.delta_mask     = delta_mask_r;
  assign out_chan.delta_low      = delta_r[LOW_W-1:0];
  assign out_chan.delta_high     = delta_r[REGS_W-1:LOW_W];
  assign out_chan.base_low       = base_regs_r[LOW_W-1:0];
  assign out_chan.base_high      = base_regs_r[REGS_W-1:LOW_W];
  assign out_chan.base_time      = base_time_r;

endmodule

[design/register_frame_delta_dumper_core.sv]
// Register frame delta dumper. Timestamped register-write chunks for a 14-register
// sound chip enter on in_chan, one transfer per clock when the block is ready. Chunks
// that fall before the next frame boundary (base time plus cfg frame duration) are merged
// into a working register set. The first chunk at or past the boundary closes the frame
// without being merged: if any register changed against the committed base (the envelope
// register counts whenever it was written), one result leaves on out_chan carrying the
// skip count, the delta and the old base; then the working set becomes the new base and
// the boundary moves on by exactly one frame. The block takes one chunk per clock while
// its queue has room; a result passes through the queue and the output register.
// The back end merges or closes one queued chunk per cycle, a close only when the output
// register is free; a four-entry queue between the classifying front end and back end
// absorbs up to four chunks while a finished result waits on out_chan, and in_chan.ready
// drops only once that queue is full. The frame duration register resets to 20 ms and
// may be rewritten through cfg_wr_en and cfg_wr_data while no chunk is in flight.
module register_frame_delta_dumper_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rfdd_pkg::DUR_W-1:0]  cfg_wr_data,
  rfdd_in_if.sink                     in_chan,
  rfdd_out_if.source                  out_chan
);
  import rfdd_pkg::*;

  // Classified chunks travel from the front end to the back end through the queue.
  logic        push;
  rfdd_entry_t push_entry;
  logic        q_full;
  logic        pop;
  rfdd_entry_t pop_entry;
  logic        pop_valid;

  // The front end owns the frame duration and the base timestamp, so it can decide
  // at transfer time whether a chunk merges or closes a frame.
  rfdd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .push        (push),
    .push_entry  (push_entry),
    .q_full      (q_full)
  );

  rfdd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid)
  );

  // The back end holds the register sets, the change mask and the skip count, and
  // drives the registered result.
  rfdd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_chan  (out_chan)
  );

endmodule

[design/rfdd_checker.sv]
`include "assert_macros.svh"

module rfdd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rfdd_pkg::SKIP_W-1:0]  out_skipped,
  input logic [rfdd_pkg::MASK_W-1:0]  out_dmask,
  input logic [rfdd_pkg::TIME_W-1:0]  out_btime
);

  // A stalled result stays valid and keeps its delta mask, base time and skip count.
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_dmask) && $stable(out_btime) &&
      $stable(out_skipped);
  endproperty

  `RFDD_ASSERT(a_out_hold, clk, rst_n, p_out_hold)

  // Reset empties the result register and the queue.
  `RFDD_ASSERT_ALWAYS(a_rst_out_idle, clk, !rst_n |=> !out_valid)
  `RFDD_ASSERT_ALWAYS(a_rst_in_ready, clk, !rst_n |=> in_ready)

  // A result is only produced for a non-empty delta, after at least one frame.
  `RFDD_ASSERT(a_out_nonzero, clk, rst_n, out_valid |-> out_dmask != '0 && out_skipped != '0)

endmodule

bind register_frame_delta_dumper_core rfdd_checker u_rfdd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_skipped (out_chan.frames_skipped),
  .out_dmask   (out_chan.delta_mask),
  .out_btime   (out_chan.base_time)
);
